// ----- src/mcop_pkg.sv -----
package mcop_pkg;

  localparam int unsigned LOG2E_Q16 = 94548;
  localparam int unsigned LN2_Q16   = 45426;
  localparam int unsigned ONE_Q16   = 65536;

  localparam logic [2:0] REG_ADJUSTED_SPOT   = 3'd0;
  localparam logic [2:0] REG_STRIKE_PRICE    = 3'd1;
  localparam logic [2:0] REG_DIFFUSION_SCALE = 3'd2;
  localparam logic [2:0] REG_DISCOUNT_FACTOR = 3'd3;
  localparam logic [2:0] REG_OPTION_KIND     = 3'd4;

  localparam logic KIND_CALL = 1'b0;
  localparam logic KIND_PUT  = 1'b1;

  typedef struct packed {
    logic [31:0] adjusted_spot;
    logic [31:0] strike_price;
    logic [15:0] diffusion_scale;
    logic [15:0] discount_factor;
    logic        option_kind;
  } cfg_t;

  typedef struct packed {
    logic [31:0] payoff;
    logic        last;
  } qword_t;

  function automatic logic [16:0] pow2_frac(input logic [3:0] idx);
    logic [16:0] v;
    begin
      case (idx)
        4'd0:    v = 17'd65536;
        4'd1:    v = 17'd68438;
        4'd2:    v = 17'd71468;
        4'd3:    v = 17'd74632;
        4'd4:    v = 17'd77936;
        4'd5:    v = 17'd81386;
        4'd6:    v = 17'd84990;
        4'd7:    v = 17'd88752;
        4'd8:    v = 17'd92682;
        4'd9:    v = 17'd96785;
        4'd10:   v = 17'd101070;
        4'd11:   v = 17'd105545;
        4'd12:   v = 17'd110217;
        4'd13:   v = 17'd115097;
        4'd14:   v = 17'd120193;
        default: v = 17'd125515;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- src/monte_carlo_option_payoff.sv -----
// monte carlo option payoff accumulator
// input channel: in_valid / in_stall carry one word per simulated path, a
// signed q4.12 normal sample and a last_path flag. a word is taken at a clock
// edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall carry one word per run, the
// discounted mean payoff (q16.16) and the number of paths in the run.
// configuration: cfg_en writes cfg_data into register cfg_index (0 spot,
// 1 strike, 2 scale, 3 discount, 4 call/put); write only while idle.
// throughput: one sample per cycle through the 7-stage price pipeline into a
// 4-word queue until a full queue stalls it; the accumulator takes one word
// per cycle while accumulating. a last path word goes on through 6 more price
// stages, the queue write, the accumulate, the bit-serial 64/32 divider that
// forms the mean, and the discount multiply before its result is shown.
// during the divide the queue fills and then stalls the input.
// reset clears the pipeline, queue, run totals and output valid, and loads
// the registers with their defaults (discount near 1.0, call payoff).
// a stalled output holds its word; the back end stops at the next run end.
module monte_carlo_option_payoff (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] normal_sample,
  input  logic               last_path,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        option_price,
  output logic [31:0]        paths_counted
);
  import mcop_pkg::*;

  cfg_t   cfg;
  qword_t push_word, head;
  logic   push, pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adjusted_spot   <= '0;
      cfg.strike_price    <= '0;
      cfg.diffusion_scale <= '0;
      cfg.discount_factor <= 16'hFFFF;
      cfg.option_kind     <= KIND_CALL;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_ADJUSTED_SPOT:   cfg.adjusted_spot   <= cfg_data;
        REG_STRIKE_PRICE:    cfg.strike_price    <= cfg_data;
        REG_DIFFUSION_SCALE: cfg.diffusion_scale <= cfg_data[15:0];
        REG_DISCOUNT_FACTOR: cfg.discount_factor <= cfg_data[15:0];
        REG_OPTION_KIND:     cfg.option_kind     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mcop_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .normal_sample (normal_sample),
    .last_path     (last_path),
    .push          (push),
    .push_word     (push_word),
    .q_full        (q_full)
  );

  mcop_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  mcop_back u_back (
    .clk             (clk),
    .rst             (rst),
    .discount_factor (cfg.discount_factor),
    .head            (head),
    .empty           (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .option_price    (option_price),
    .paths_counted   (paths_counted)
  );

endmodule

// ----- src/mcop_front.sv -----
module mcop_front (
  input  logic                  clk,
  input  logic                  rst,
  input  mcop_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [15:0]    normal_sample,
  input  logic                  last_path,
  output logic                  push,
  output mcop_pkg::qword_t      push_word,
  input  logic                  q_full
);
  import mcop_pkg::*;

  logic [7:1] v;
  logic [7:1] lst;
  logic       advance;

  logic signed [32:0] prod;
  logic signed [49:0] y;
  logic [11:0]        a;
  logic [3:0]         i3, i4;
  logic signed [7:0]  n3, n4, n5, n6;
  logic [16:0]        poly;
  logic [17:0]        m;
  logic [33:0]        p;
  logic [31:0]        s;

  logic [49:0] u;
  logic [15:0] f;
  logic [7:0]  k;
  logic [65:0] wide;
  logic [33:0] shr;
  logic [31:0] s_next;

  assign advance  = !(v[7] && q_full);
  assign in_stall = !advance;
  assign push     = v[7] && !q_full;

  assign u = 50'(y + (50'sd1 <<< 48));
  assign f = u[41:26];

  always_comb begin
    k      = 8'(-n6);
    wide   = 66'({32'd0, p} << n6[4:0]);
    shr    = p >> k[5:0];
    s_next = 32'd0;
    if (!n6[7]) begin
      if (n6 >= 8'sd32) s_next = (p != 34'd0) ? 32'hFFFF_FFFF : 32'd0;
      else s_next = (wide[65:32] != 34'd0) ? 32'hFFFF_FFFF : wide[31:0];
    end else if (k < 8'd64) begin
      s_next = (shr[33:32] != 2'd0) ? 32'hFFFF_FFFF : shr[31:0];
    end
  end

  always_comb begin
    push_word.last = lst[7];
    if (cfg.option_kind == KIND_CALL)
      push_word.payoff = (s > cfg.strike_price) ? s - cfg.strike_price : 32'd0;
    else
      push_word.payoff = (cfg.strike_price > s) ? cfg.strike_price - s : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (advance) begin
      v <= {v[6:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lst  <= {lst[6:1], last_path};
      prod <= 33'($signed({1'b0, cfg.diffusion_scale}) * normal_sample);
      y    <= 50'(prod * $signed({1'b0, 17'(LOG2E_Q16)}));
      a    <= 12'((28'(f[11:0]) * 28'(LN2_Q16)) >> 16);
      i3   <= f[15:12];
      n3   <= $signed(u[49:42] - 8'd64);
      poly <= 17'(ONE_Q16) + 17'(a) + 17'((24'(a) * 24'(a)) >> 17);
      i4   <= i3;
      n4   <= n3;
      m    <= 18'((34'(pow2_frac(i4)) * 34'(poly)) >> 16);
      n5   <= n4;
      p    <= 34'((50'(cfg.adjusted_spot) * 50'(m)) >> 16);
      n6   <= n5;
      s    <= s_next;
    end
  end

endmodule

// ----- src/mcop_queue.sv -----
module mcop_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mcop_pkg::qword_t push_word,
  output logic             full,
  input  logic             pop,
  output mcop_pkg::qword_t head,
  output logic             empty
);
  import mcop_pkg::*;

  qword_t     mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  assign full  = (count == 3'd4);
  assign empty = (count == 3'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

// ----- src/mcop_back.sv -----
module mcop_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      discount_factor,
  input  mcop_pkg::qword_t head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      option_price,
  output logic [31:0]      paths_counted
);
  import mcop_pkg::*;

  typedef enum logic [1:0] {ACC, DIV, FIN} state_t;

  state_t      state;
  logic [63:0] total;
  logic [31:0] count;
  logic [63:0] quo;
  logic [31:0] rem;
  logic [31:0] den;
  logic [5:0]  step;

  logic [64:0] sum;
  logic [63:0] total_next;
  logic [31:0] count_next;
  logic [32:0] rem_sh;
  logic        fits;
  logic [31:0] mean;
  logic        out_free;

  assign pop        = (state == ACC) && !empty;
  assign sum        = {1'b0, total} + 65'(head.payoff);
  assign total_next = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
  assign count_next = (count == 32'hFFFF_FFFF) ? count : count + 32'd1;
  assign rem_sh     = {rem, quo[63]};
  assign fits       = rem_sh >= {1'b0, den};
  assign mean       = (quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : quo[31:0];
  assign out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ACC;
      total     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (out_valid && !out_stall && state != FIN) out_valid <= 1'b0;
      unique case (state)
        ACC: begin
          if (pop) begin
            if (head.last) begin
              quo   <= total_next;
              den   <= count_next;
              rem   <= '0;
              step  <= '0;
              total <= '0;
              count <= '0;
              state <= DIV;
            end else begin
              total <= total_next;
              count <= count_next;
            end
          end
        end
        DIV: begin
          rem  <= fits ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];
          quo  <= {quo[62:0], fits};
          step <= step + 6'd1;
          if (step == 6'd63) state <= FIN;
        end
        FIN: begin
          if (out_free) begin
            option_price  <= 32'((48'(mean) * 48'(discount_factor)) >> 16);
            paths_counted <= den;
            out_valid     <= 1'b1;
            state         <= ACC;
          end
        end
        default: state <= ACC;
      endcase
    end
  end

endmodule

// ----- src/mcop_checker.sv -----
module mcop_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] option_price,
  input logic [31:0] paths_counted
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(option_price) && $stable(paths_counted))
    else $error("result word changed while stalled");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> paths_counted != 32'd0)
    else $error("result word with no paths");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word right after reset");

endmodule

bind monte_carlo_option_payoff mcop_checker u_mcop_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .option_price  (option_price),
  .paths_counted (paths_counted)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import mcop_pkg::*;

  logic               clk;
  logic               rst;
  logic               cfg_en;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] normal_sample;
  logic               last_path;
  logic               out_valid;
  logic               out_stall;
  logic [31:0]        option_price;
  logic [31:0]        paths_counted;

  monte_carlo_option_payoff u_dut (
    .clk(clk), .rst(rst), .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .normal_sample(normal_sample),
    .last_path(last_path), .out_valid(out_valid), .out_stall(out_stall),
    .option_price(option_price), .paths_counted(paths_counted)
  );

  typedef struct {
    logic [15:0] sample;
    logic        last;
  } path_word_t;

  typedef struct {
    logic [31:0] price;
    logic [31:0] count;
  } run_result_t;

  localparam int LIMIT_CYCLES = 2000000;

  path_word_t  pending_paths[$];
  run_result_t expected_runs[$];

  logic [31:0] m_spot;
  logic [31:0] m_strike;
  logic [15:0] m_scale;
  logic [15:0] m_discount;
  logic        m_kind;
  logic [63:0] m_total;
  logic [31:0] m_count;

  int  error_count;
  int  cycle_count;
  bit  idle_enable;
  int  in_gap;
  int  out_gap;
  logic [31:0] cfg_q_data;
  logic [2:0]  cfg_q_index;
  bit          cfg_q_en;

  function automatic logic [31:0] frac_table(input logic [3:0] idx);
    logic [31:0] t [16];
    t = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
          92682, 96785, 101070, 105545, 110217, 115097, 120193, 125515};
    return t[idx];
  endfunction

  function automatic logic [31:0] price_at_expiry(input logic [15:0] raw);
    logic signed [63:0] y;
    logic [63:0] u;
    int          n;
    logic [15:0] f;
    logic [63:0] r;
    logic [63:0] a;
    logic [63:0] poly;
    logic [63:0] mant;
    logic [63:0] p;
    y = $signed({48'd0, m_scale}) * $signed({{48{raw[15]}}, raw}) * 64'sd94548;
    u = y + (64'd1 << 48);
    n = int'(u >> 42) - 64;
    f = u[41:26];
    r = {52'd0, f[11:0]};
    a = (r * 64'd45426) >> 16;
    poly = 64'd65536 + a + ((a * a) >> 17);
    mant = ({32'd0, frac_table(f[15:12])} * poly) >> 16;
    p = ({32'd0, m_spot} * mant) >> 16;
    if (n >= 0) begin
      if (n >= 32 && p != 0) return 32'hFFFFFFFF;
      if (p > 64'hFFFFFFFF) return 32'hFFFFFFFF;
      if (p > (64'hFFFFFFFF >> n)) return 32'hFFFFFFFF;
      return 32'(p << n);
    end
    if (-n >= 64) return 32'd0;
    p = p >> (-n);
    return (p > 64'hFFFFFFFF) ? 32'hFFFFFFFF : p[31:0];
  endfunction

  task automatic accumulate_path(input path_word_t w);
    logic [31:0] s;
    logic [31:0] pay;
    logic [63:0] mean;
    run_result_t res;
    s = price_at_expiry(w.sample);
    if (m_kind == KIND_CALL) pay = (s > m_strike) ? s - m_strike : 32'd0;
    else pay = (m_strike > s) ? m_strike - s : 32'd0;
    if (m_total > 64'hFFFFFFFFFFFFFFFF - pay) m_total = 64'hFFFFFFFFFFFFFFFF;
    else m_total = m_total + pay;
    if (m_count != 32'hFFFFFFFF) m_count = m_count + 1;
    if (w.last) begin
      mean = m_total / m_count;
      if (mean > 64'hFFFFFFFF) mean = 64'hFFFFFFFF;
      res.price = 32'((mean * m_discount) >> 16);
      res.count = m_count;
      expected_runs.insert(expected_runs.size(), res);
      m_total = 0;
      m_count = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    error_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    cfg_en <= cfg_q_en;
    cfg_index <= cfg_q_index;
    cfg_data <= cfg_q_data;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        accumulate_path('{normal_sample, last_path});
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else if (pending_paths.size() > 0) begin
          normal_sample <= pending_paths[0].sample;
          last_path <= pending_paths[0].last;
          in_valid <= 1'b1;
          void'(pending_paths.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_runs.size() == 0) begin
          report_mismatch("unexpected word", option_price, 32'd0);
        end else begin
          if (option_price !== expected_runs[0].price)
            report_mismatch("option_price", option_price, expected_runs[0].price);
          if (paths_counted !== expected_runs[0].count)
            report_mismatch("paths_counted", paths_counted, expected_runs[0].count);
          void'(expected_runs.pop_front());
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_q_en = 1'b1;
    cfg_q_index = idx;
    cfg_q_data = val;
    @(posedge clk);
    @(posedge clk);
    cfg_q_en = 1'b0;
    case (idx)
      REG_ADJUSTED_SPOT:   m_spot = val;
      REG_STRIKE_PRICE:    m_strike = val;
      REG_DIFFUSION_SCALE: m_scale = val[15:0];
      REG_DISCOUNT_FACTOR: m_discount = val[15:0];
      default:             m_kind = val[0];
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_paths.size() > 0 || in_valid || expected_runs.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic push_path(input logic [15:0] s, input logic l);
    path_word_t w;
    w.sample = s;
    w.last = l;
    pending_paths.insert(pending_paths.size(), w);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8191) - 4096);
      2: return 16'($urandom_range(0, 24575) - 12288);
      default: return 16'($urandom_range(0, 2047) - 1024);
    endcase
  endfunction

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'hFFFFFFFF;
      2: return 32'd0;
      default: return $urandom_range(1, 200) << 16;
    endcase
  endfunction

  initial begin
    int sent;
    int len;
    cycle_count = 0;
    error_count = 0;
    idle_enable = 1'b1;
    cfg_q_en = 1'b0;
    cfg_q_index = REG_ADJUSTED_SPOT;
    cfg_q_data = 32'd0;
    cfg_en = 1'b0;
    cfg_index = REG_ADJUSTED_SPOT;
    cfg_data = 32'd0;
    in_valid = 1'b0;
    normal_sample = 16'sd0;
    last_path = 1'b0;
    out_stall = 1'b0;
    m_spot = 0;
    m_strike = 0;
    m_scale = 0;
    m_discount = 16'hFFFF;
    m_kind = KIND_CALL;
    m_total = 0;
    m_count = 0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero scale, single path run at reset defaults
    push_path(16'h1000, 1'b1);
    wait_drained();
    write_reg(REG_ADJUSTED_SPOT, 32'd100 << 16);
    write_reg(REG_STRIKE_PRICE, 32'd90 << 16);
    write_reg(REG_DIFFUSION_SCALE, 16'd3277);
    write_reg(REG_DISCOUNT_FACTOR, 16'd62000);
    write_reg(REG_OPTION_KIND, KIND_CALL);
    push_path(16'h7FFF, 1'b0);
    push_path(16'h8000, 1'b0);
    push_path(16'h0000, 1'b0);
    push_path(16'hFFFF, 1'b0);
    push_path(16'h0001, 1'b1);
    push_path(16'h2000, 1'b1);
    wait_drained();
    write_reg(REG_OPTION_KIND, KIND_PUT);
    push_path(16'h8000, 1'b0);
    push_path(16'h7FFF, 1'b0);
    push_path(16'hE000, 1'b1);
    wait_drained();
    // price overflow and saturation
    write_reg(REG_ADJUSTED_SPOT, 32'hFFFFFFFF);
    write_reg(REG_DIFFUSION_SCALE, 16'hFFFF);
    write_reg(REG_STRIKE_PRICE, 32'd0);
    write_reg(REG_OPTION_KIND, KIND_CALL);
    write_reg(REG_DISCOUNT_FACTOR, 16'd0);
    push_path(16'h7FFF, 1'b0);
    push_path(16'h8000, 1'b1);
    wait_drained();
    write_reg(REG_DISCOUNT_FACTOR, 16'hFFFF);
    write_reg(REG_STRIKE_PRICE, 32'hFFFFFFFF);
    write_reg(REG_OPTION_KIND, KIND_PUT);
    push_path(16'h8000, 1'b0);
    push_path(16'h7FFF, 1'b0);
    push_path(16'h4000, 1'b1);
    wait_drained();

    sent = 0;
    while (sent < 1200) begin
      if (sent > 1000) idle_enable = 1'b0;
      write_reg(REG_ADJUSTED_SPOT, rand_q16());
      write_reg(REG_STRIKE_PRICE, rand_q16());
      write_reg(REG_DIFFUSION_SCALE, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                     : 16'($urandom_range(0, 8192)));
      write_reg(REG_DISCOUNT_FACTOR, 16'($urandom));
      write_reg(REG_OPTION_KIND, $urandom_range(0, 1));
      repeat ($urandom_range(3, 8)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) push_path(rand_sample(), k == len - 1);
        sent += len;
      end
      wait_drained();
    end

    if (error_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

endmodule
